### hdl/ordered_array_list_engine_core_assert.svh
// Assertion macros shared by the list engine RTL.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define OLEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/olec_pkg.sv
// Shared types and constants for the ordered list engine.
`default_nettype none

package olec_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_DELETE_AT  = 3'd1,
        OP_DELETE_VAL = 3'd2,
        OP_GET        = 3'd3,
        OP_LOCATE     = 3'd4,
        OP_CLEAR      = 3'd5
    } olec_op_t;

    typedef struct packed {
        logic                     insert_en;
        logic                     del_at_en;
        logic                     del_val_en;
        logic        [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] key;
        logic        [POS_W-1:0]  count;
    } olec_ctrl_t;

endpackage

`default_nettype wire

### hdl/olec_cell.sv
// One list slot: holds an entry, compares it to the key, shifts with its neighbors.
`default_nettype none

module olec_cell #(
    parameter int IDX = 0
) (
    input  wire                                  clk,
    input  wire olec_pkg::olec_ctrl_t            ctrl,
    input  wire logic signed [olec_pkg::DATA_W-1:0] left_value,
    input  wire logic signed [olec_pkg::DATA_W-1:0] right_value,
    input  wire logic                            seen_in,
    output logic                                 seen_out,
    output logic                                 first_hit,
    output logic signed [olec_pkg::DATA_W-1:0]   value
);
    import olec_pkg::*;

    localparam logic [POS_W-1:0] POS_ID = POS_W'(IDX + 1);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     hit;

    assign hit       = (POS_ID <= ctrl.count) && (value_reg == ctrl.key);
    assign seen_out  = seen_in | hit;
    assign first_hit = hit & ~seen_in;
    assign value     = value_reg;

    always_comb
    begin
        priority if (ctrl.insert_en && (POS_ID > ctrl.pos))
            value_next = left_value;
        else if (ctrl.insert_en && (POS_ID == ctrl.pos))
            value_next = ctrl.key;
        else if (ctrl.del_at_en && (POS_ID >= ctrl.pos))
            value_next = right_value;
        else if (ctrl.del_val_en && seen_out)
            value_next = right_value;
        else
            value_next = value_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### hdl/ordered_array_list_engine_core.sv
// Top level: bounded ordered list built as a row of shifting cells.
//
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | op[2:0], position[7:3], item_value[39:8]
//  m_axis  | out | ok[0], read_value[32:1], found_position[37:33], list_length[42:38]
//
//  One transaction per cycle while s_axis_tready is high; its result is registered
//  and appears in the next cycle. Every cell compares and shifts in that same cycle;
//  the first-match chain through the row of cells sets the path length.
//  rst_n clears the length and the output valid flag; entries and result fields are not.
//  s_axis_tready drops only while a result waits and m_axis_tready is low.
`default_nettype none

module ordered_array_list_engine_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // op, position, item_value
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // ok, read_value, found_position, list_length
);
    import olec_pkg::*;

    `include "ordered_array_list_engine_core_assert.svh"

    logic                     fire;
    logic [2:0]               op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] key;

    logic [POS_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg;
    logic                     ok_reg, ok_next;
    logic signed [DATA_W-1:0] rv_reg, rv_next;
    logic [POS_W-1:0]         fp_reg, fp_next;

    logic                     pos_ok, ins_ok, found;
    logic [POS_W-1:0]         pos_m1;
    logic [POS_W-1:0]         first_pos;
    olec_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] values [CAPACITY];
    logic [CAPACITY:0]        seen;
    logic [CAPACITY-1:0]      first_hit;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign fire          = s_axis_tvalid & s_axis_tready;
    assign op            = s_axis_tdata[2:0];
    assign pos           = s_axis_tdata[7:3];
    assign key           = s_axis_tdata[39:8];

    assign pos_ok = (pos != '0) && (pos <= count_reg);
    assign ins_ok = (pos != '0) && ({1'b0, pos} <= ({1'b0, count_reg} + 6'd1))
                    && (count_reg < POS_W'(CAPACITY));
    assign pos_m1 = pos - POS_W'(1);
    assign found  = seen[CAPACITY];

    assign ctrl.insert_en  = fire && (op == OP_INSERT) && ins_ok;
    assign ctrl.del_at_en  = fire && (op == OP_DELETE_AT) && pos_ok;
    assign ctrl.del_val_en = fire && (op == OP_DELETE_VAL);
    assign ctrl.pos        = pos;
    assign ctrl.key        = key;
    assign ctrl.count      = count_reg;

    assign seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            olec_cell #(
                .IDX (g)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .left_value  ((g == 0) ? key : values[(g == 0) ? 0 : g - 1]),
                .right_value (values[(g == CAPACITY - 1) ? g : g + 1]),
                .seen_in     (seen[g]),
                .seen_out    (seen[g + 1]),
                .first_hit   (first_hit[g]),
                .value       (values[g])
            );
        end
    endgenerate

    always_comb
    begin
        first_pos = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (first_hit[k])
                first_pos = first_pos | POS_W'(k + 1);
        end
    end

    always_comb
    begin
        ok_next    = 1'b0;
        rv_next    = '0;
        fp_next    = '0;
        count_next = count_reg;
        unique case (op)
            OP_INSERT:
            begin
                ok_next = ins_ok;
                if (ins_ok)
                    count_next = count_reg + POS_W'(1);
            end
            OP_DELETE_AT:
            begin
                ok_next = pos_ok;
                if (pos_ok)
                begin
                    rv_next    = values[pos_m1[IDX_W-1:0]];
                    count_next = count_reg - POS_W'(1);
                end
            end
            OP_DELETE_VAL:
            begin
                ok_next = found;
                if (found)
                begin
                    rv_next    = key;
                    count_next = count_reg - POS_W'(1);
                end
            end
            OP_GET:
            begin
                ok_next = pos_ok;
                if (pos_ok)
                    rv_next = values[pos_m1[IDX_W-1:0]];
            end
            OP_LOCATE:
            begin
                ok_next = found;
                fp_next = first_pos;
            end
            OP_CLEAR:
            begin
                ok_next    = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg <= ok_next;
            rv_reg <= rv_next;
            fp_reg <= fp_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, count_reg, fp_reg, rv_reg, ok_reg};

    `OLEC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= POS_W'(CAPACITY),
        "list length above capacity")
    `OLEC_ASSERT_NOW(a_found_ok, out_valid_reg && (fp_reg != '0), ok_reg,
        "found position without ok")
    `OLEC_ASSERT_NEXT(a_clear, fire && (op == OP_CLEAR), (count_reg == '0) && ok_reg,
        "clear did not empty the list")
    `OLEC_ASSERT_NEXT(a_result, fire, out_valid_reg,
        "accepted transaction gave no result")

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for the ordered list engine: queued requests, a scoreboard model and a result check.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import olec_pkg::*;

    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;
    localparam int         NUM_ITEMS = 900;

    typedef struct {
        olec_op_t                 op;
        logic        [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] item_value;
    } list_request_t;

    typedef struct {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic        [POS_W-1:0]  found_position;
        logic        [POS_W-1:0]  list_length;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [47:0] m_axis_tdata;

    list_request_t pending_requests[$];
    list_result_t  expected_results[$];

    logic signed [DATA_W-1:0] model_entries [CAPACITY];
    int                       model_fill;

    int          gen_list[$];
    int          mismatch_count;
    int          results_seen;
    int          ok_count;
    int          full_rejects;
    int          op_count [8];
    int          burst_left;
    int          gap_left;
    int unsigned ready_cycle;

    ordered_array_list_engine_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Scoreboard model: applies one request to the shadow list.
    function automatic list_result_t list_model_apply(list_request_t req);
        list_result_t res;
        int           pos;
        int           hit;
        res = '{ok: 1'b0, read_value: '0, found_position: '0, list_length: '0};
        pos = int'(req.position);
        hit = 0;
        if (req.op == OP_DELETE_VAL || req.op == OP_LOCATE)
        begin
            for (int k = model_fill - 1; k >= 0; k--)
                if (model_entries[k] == req.item_value)
                    hit = k + 1;
        end
        case (req.op)
            OP_INSERT:
            begin
                if (model_fill == CAPACITY)
                    full_rejects++;
                if (pos >= 1 && pos <= model_fill + 1 && model_fill < CAPACITY)
                begin
                    for (int k = model_fill; k >= pos; k--)
                        model_entries[k] = model_entries[k-1];
                    model_entries[pos-1] = req.item_value;
                    model_fill++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE_AT, OP_DELETE_VAL:
            begin
                if (req.op == OP_DELETE_VAL)
                    pos = hit;
                if (pos >= 1 && pos <= model_fill)
                begin
                    res.read_value = model_entries[pos-1];
                    for (int k = pos; k < model_fill; k++)
                        model_entries[k-1] = model_entries[k];
                    model_fill--;
                    res.ok = 1'b1;
                end
            end
            OP_GET:
            begin
                if (pos >= 1 && pos <= model_fill)
                begin
                    res.read_value = model_entries[pos-1];
                    res.ok = 1'b1;
                end
            end
            OP_LOCATE:
            begin
                res.found_position = POS_W'(hit);
                res.ok = (hit != 0);
            end
            OP_CLEAR:
            begin
                model_fill = 0;
                res.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.list_length = POS_W'(model_fill);
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // Stimulus generation; gen_list follows the list contents to aim positions and values.
    task automatic queue_request(logic [2:0] op, int pos, logic signed [31:0] val);
        list_request_t req;
        int            idx;
        req.op         = olec_op_t'(op);
        req.position   = POS_W'(pos);
        req.item_value = val;
        pending_requests.push_back(req);
        idx = -1;
        if (op == OP_DELETE_VAL)
        begin
            for (int k = gen_list.size() - 1; k >= 0; k--)
                if (gen_list[k] == val)
                    idx = k;
        end
        else if (op == OP_DELETE_AT && pos >= 1 && pos <= gen_list.size())
        begin
            idx = pos - 1;
        end
        if (idx >= 0)
            gen_list.delete(idx);
        if (op == OP_INSERT && pos >= 1 && pos <= gen_list.size() + 1
            && gen_list.size() < CAPACITY)
            gen_list.insert(pos - 1, val);
        if (op == OP_CLEAR)
            gen_list = {};
    endtask

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 3 && gen_list.size() > 0)
            return gen_list[$urandom_range(0, gen_list.size() - 1)];
        case (sel)
            3:       return 32'sh7fff_ffff;
            4:       return 32'sh8000_0000;
            5:       return 32'(int'($urandom_range(0, 3)) - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_position(int limit);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, (limit < 1) ? 1 : limit);
        return $urandom_range(0, 31);
    endfunction

    initial
    begin
        int          seg_left;
        int          mode;
        int          roll;
        int          len;
        logic [2:0]  op;
        seg_left = 0;
        mode = 0;
        // directed part: bounds, every op, rejects, undefined ops
        queue_request(OP_INSERT, 0, 32'sd7);
        queue_request(OP_INSERT, 2, 32'sd7);
        queue_request(OP_GET, 1, 32'sd0);
        queue_request(OP_DELETE_AT, 1, 32'sd0);
        queue_request(OP_LOCATE, 0, 32'sd0);
        queue_request(OP_INSERT, 1, 32'sh7fff_ffff);
        queue_request(OP_INSERT, 1, 32'sh8000_0000);
        queue_request(OP_INSERT, 3, -32'sd1);
        queue_request(OP_INSERT, 2, -32'sd1);
        queue_request(OP_INSERT, 31, 32'sd0);
        queue_request(OP_GET, 0, 32'sd0);
        queue_request(OP_GET, 1, 32'sd0);
        queue_request(OP_GET, 4, 32'sd0);
        queue_request(OP_GET, 5, 32'sd0);
        queue_request(OP_LOCATE, 0, -32'sd1);
        queue_request(OP_LOCATE, 31, 32'sd12345);
        queue_request(OP_DELETE_VAL, 0, -32'sd1);
        queue_request(OP_DELETE_VAL, 0, 32'sd12345);
        queue_request(OP_DELETE_AT, 31, 32'sd0);
        queue_request(OP_DELETE_AT, 3, 32'sd0);
        queue_request(OP_RSVD_6, 1, 32'sh7fff_ffff);
        queue_request(OP_RSVD_7, 31, -32'sd1);
        queue_request(OP_CLEAR, 0, 32'sd0);
        queue_request(OP_GET, 1, 32'sd0);
        queue_request(OP_DELETE_VAL, 0, 32'sd0);
        // random part in segments: grow, churn, or drain the list
        while (pending_requests.size() < NUM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                mode = $urandom_range(0, 2);
            end
            seg_left--;
            len = gen_list.size();
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = OP_CLEAR;
            else if (roll < 4)
                op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
            else if (mode == 0)
                op = (roll < 70) ? OP_INSERT : 3'($urandom_range(1, 4));
            else if (mode == 2)
                op = (roll < 40) ? OP_DELETE_AT : (roll < 65) ? OP_DELETE_VAL
                                                              : 3'($urandom_range(0, 4));
            else
                op = 3'($urandom_range(0, 4));
            queue_request(op, pick_position((op == OP_INSERT) ? len + 1 : len), pick_value());
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic busy;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            model_fill    = 0;
            burst_left    = 1;
            gap_left      = 0;
        end
        else
        begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                op_count[pending_requests[0].op]++;
                expected_results.push_back(list_model_apply(pending_requests.pop_front()));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_requests[0].item_value,
                                      pending_requests[0].position,
                                      3'(pending_requests[0].op)};
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stretches of random stalls and of heavy stalls alternate with stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_cycle   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no pending request: tdata 0x%0h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.ok)
                        ok_count++;
                    compare_field("ok", 32'(exp_r.ok), 32'(m_axis_tdata[0]));
                    compare_field("read_value", exp_r.read_value, m_axis_tdata[32:1]);
                    compare_field("found_position", 32'(exp_r.found_position),
                                  32'(m_axis_tdata[37:33]));
                    compare_field("list_length", 32'(exp_r.list_length),
                                  32'(m_axis_tdata[42:38]));
                end
            end
            ready_cycle++;
            if (ready_cycle[7])
                m_axis_tready <= 1'b1;
            else if (ready_cycle[6])
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            else
                m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (pending_requests.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        $display("Covered %0d transactions: insert %0d, delete-at %0d, delete-by-value %0d,",
                 results_seen, op_count[OP_INSERT], op_count[OP_DELETE_AT],
                 op_count[OP_DELETE_VAL]);
        $display("  get %0d, locate %0d, clear %0d, undefined %0d; %0d ok, %0d inserts on full",
                 op_count[OP_GET], op_count[OP_LOCATE], op_count[OP_CLEAR],
                 op_count[OP_RSVD_6] + op_count[OP_RSVD_7], ok_count, full_rejects);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout waiting for results");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
